[design/chs_pkg.sv]
// Shared constants, codes and transfer types of the chained hash set.
package chs_pkg;

  localparam int BUCKETS    = 23;
  localparam int POOL_NODES = 64;

  localparam int KEY_W  = 31;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  // A link holds a node index plus one, so zero can mean "no node".
  localparam int LINK_W = $clog2(POOL_NODES + 1);

  localparam int STATUS_W  = 3;
  localparam int BUCKET_OW = 5;

  // Reciprocal of the bucket count for the division hash.
  localparam int RECIP_SHIFT = KEY_W + BKT_W;
  localparam int RECIP_W     = KEY_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / BUCKETS);
  localparam int PROD_W = KEY_W + RECIP_W;
  localparam int Q_W    = PROD_W - RECIP_SHIFT;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } chs_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BUCKET_OW-1:0] bucket;
  } chs_out_t;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bucket;
  } chs_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } chs_qstat_t;

endpackage

[design/chs_front.sv]
// Front end: accepts items and hashes each key to its bucket.
module chs_front
  import chs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  chs_in_t    in_data,
  output logic       push,
  output chs_item_t  push_item,
  input  chs_qstat_t qstat
);

  logic             s1_valid_r;
  logic             s1_op_r;
  logic [KEY_W-1:0] s1_key_r;
  logic [Q_W-1:0]   s1_q_r;

  logic              accept;
  logic              advance;
  logic [PROD_W-1:0] prod;
  logic [KEY_W:0]    q_times_b;
  logic [KEY_W:0]    rem;
  logic [KEY_W:0]    rem_fix;

  assign advance  = !s1_valid_r || !qstat.full;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // The quotient estimate is low by at most one.
  assign prod = PROD_W'(in_data.key) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_data.operation;
      s1_key_r <= in_data.key;
      s1_q_r   <= prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  always_comb begin
    q_times_b = (KEY_W+1)'(s1_q_r) * (KEY_W+1)'(BUCKETS);
    rem       = (KEY_W+1)'(s1_key_r) - q_times_b;
    rem_fix   = (rem >= (KEY_W+1)'(BUCKETS)) ? rem - (KEY_W+1)'(BUCKETS) : rem;
  end

  assign push                = s1_valid_r && !qstat.full;
  assign push_item.operation = s1_op_r;
  assign push_item.key       = s1_key_r;
  assign push_item.bucket    = BKT_W'(rem_fix);

endmodule

[design/chs_queue.sv]
// Two-entry queue between the hashing front end and the chain walker.
module chs_queue
  import chs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  chs_item_t  push_item,
  input  logic       pop,
  output chs_item_t  head_item,
  output chs_qstat_t qstat
);

  localparam int DEPTH = 2;

  chs_item_t  entry_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item   = entry_r[rd_ptr_r];
  assign qstat.empty = (count_r == 2'd0);
  assign qstat.full  = (count_r == 2'(DEPTH));

endmodule

[design/chs_back.sv]
// Back end: walks the bucket chain, allocates nodes and returns results.
module chs_back
  import chs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chs_item_t  head_item,
  input  chs_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output chs_out_t   out_data
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_HEAD    = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_READ    = 7'b0001000,
    S_LINK_RD = 7'b0010000,
    S_LINK_WR = 7'b0100000,
    S_LINK_UP = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [BKT_W-1:0]  bkt_r;
  logic [LINK_W-1:0] link_r, link_nxt;
  logic [LINK_W-1:0] steps_r, steps_nxt;
  logic [LINK_W-1:0] used_r, used_nxt;
  logic [LINK_W-1:0] head_r [BUCKETS];
  logic              out_valid_r;
  chs_out_t          out_data_r;

  logic [KEY_W-1:0]  key_mem [POOL_NODES];
  logic [LINK_W-1:0] next_mem [POOL_NODES];
  logic [KEY_W-1:0]  key_rd_r;
  logic [LINK_W-1:0] next_rd_r;

  logic [LINK_W-1:0]   head_cur;
  logic                walkable;
  logic [NODE_W-1:0]   rd_addr;
  logic                key_we;
  logic                next_we;
  logic [NODE_W-1:0]   next_waddr;
  logic [LINK_W-1:0]   next_wdata;
  logic                head_we;
  logic                finish;
  logic [STATUS_W-1:0] status_nxt;
  logic [NODE_W-1:0]   new_node;
  logic [NODE_W-1:0]   head_node;
  logic [NODE_W-1:0]   link_node;

  assign head_cur  = head_r[bkt_r];
  assign new_node  = NODE_W'(used_r);
  assign head_node = NODE_W'(head_cur - LINK_W'(1));
  assign link_node = NODE_W'(link_r - LINK_W'(1));
  assign walkable  = (link_r != '0) && (link_r <= LINK_W'(POOL_NODES))
                     && (steps_r < LINK_W'(POOL_NODES));
  assign pop       = (state_r == S_IDLE) && !qstat.empty && !out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    link_nxt   = link_r;
    steps_nxt  = steps_r;
    used_nxt   = used_r;
    rd_addr    = link_node;
    key_we     = 1'b0;
    next_we    = 1'b0;
    next_waddr = new_node;
    next_wdata = '0;
    head_we    = 1'b0;
    finish     = 1'b0;
    status_nxt = ST_NOT_FOUND;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        link_nxt  = head_cur;
        steps_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (walkable) begin
          state_nxt = S_READ;
        end else if (op_r == OP_LOOKUP) begin
          finish     = 1'b1;
          status_nxt = ST_NOT_FOUND;
        end else if (used_r >= LINK_W'(POOL_NODES)) begin
          finish     = 1'b1;
          status_nxt = ST_POOL_FULL;
        end else begin
          key_we = 1'b1;
          if (head_cur == '0) begin
            next_we    = 1'b1;
            next_wdata = '0;
            head_we    = 1'b1;
            used_nxt   = used_r + LINK_W'(1);
            finish     = 1'b1;
            status_nxt = ST_INSERTED;
          end else begin
            state_nxt = S_LINK_RD;
          end
        end
      end
      S_READ: begin
        if (key_rd_r == key_r) begin
          finish     = 1'b1;
          status_nxt = (op_r == OP_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
        end else begin
          link_nxt  = next_rd_r;
          steps_nxt = steps_r + LINK_W'(1);
          state_nxt = S_CHECK;
        end
      end
      S_LINK_RD: begin
        rd_addr   = head_node;
        state_nxt = S_LINK_WR;
      end
      S_LINK_WR: begin
        next_we    = 1'b1;
        next_waddr = new_node;
        next_wdata = next_rd_r;
        state_nxt  = S_LINK_UP;
      end
      S_LINK_UP: begin
        next_we    = 1'b1;
        next_waddr = head_node;
        next_wdata = used_r + LINK_W'(1);
        used_nxt   = used_r + LINK_W'(1);
        finish     = 1'b1;
        status_nxt = ST_INSERTED;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (finish) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (head_we) begin
        head_r[bkt_r] <= used_r + LINK_W'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r  <= head_item.operation;
      key_r <= head_item.key;
      bkt_r <= head_item.bucket;
    end
    link_r  <= link_nxt;
    steps_r <= steps_nxt;
    if (finish) begin
      out_data_r.status <= status_nxt;
      out_data_r.bucket <= BUCKET_OW'(bkt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[new_node] <= key_r;
    end
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_r <= next_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/chained_hash_set.sv]
// Top level of the chained hash set: front end, queue and chain walker.

// The block keeps a set of 31-bit keys in a hash table with separate chaining.
// Each input transfer carries an operation (insert or look up) and a key, and
// yields exactly one result transfer with a status and the bucket the key
// hashed to (key modulo the bucket count), in input order. The front end
// hashes keys in a two-stage pipeline built around one reciprocal multiply and
// keeps taking input while the back end works, through a two-entry queue. The
// back end handles one item at a time and walks the key's chain in node
// memories with registered reads: an item passes through the idle, head and
// check states, then a read and a check state for every chain node visited,
// ending in the read state when the key is found on its chain, and an insert
// that links behind an existing chain head adds the link-read, link-write and
// link-update states.
// Inserted nodes are handed out in order from a pool; once it is exhausted, a
// new key reports pool full while a duplicate is still reported as such.
// Bucket heads are cleared by reset, so no clearing pass is needed.
module chained_hash_set
  import chs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  chs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output chs_out_t out_data
);

  logic       push;
  logic       pop;
  chs_item_t  push_item;
  chs_item_t  head_item;
  chs_qstat_t qstat;

  // The front end hashes each accepted key and pushes it when the queue has room.
  chs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .qstat     (qstat)
  );

  // The queue decouples hashing from the chain walk.
  chs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // The back end owns all table state and the output register.
  chs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // The front end must never push into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(push && qstat.full))
    else $error("push into a full queue");

  // The back end must never pop an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && qstat.empty))
    else $error("pop from an empty queue");

  // A popped item always ends in a result, and the back end pops only while no result is waiting.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !out_valid)
    else $error("new item started while a result is still pending");

  // Every delivered status is one of the defined codes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_INSERTED || out_data.status == ST_DUPLICATE ||
                   out_data.status == ST_POOL_FULL || out_data.status == ST_FOUND ||
                   out_data.status == ST_NOT_FOUND))
    else $error("undefined result status");
`endif

endmodule
